>>> rtl/core/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the first-match substring search block.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int POS_W  = 7;
    localparam int BYTE_W = 8;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_value;
        logic              last;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } result_t;

endpackage

>>> rtl/core/substring_first_match.sv
// ----------------------------------------------------------------------------
// substring_first_match
// First-occurrence substring search over a stream of pattern and text bytes.
// ----------------------------------------------------------------------------
// Load the pattern as kind-0 transactions, the one with last set ending it;
// then stream the text as kind-1 transactions. The text transaction with last
// set yields one result: found, the zero-based start of the first match, and
// overflow when the pattern passed PATTERN_MAX bytes or a text passed TEXT_MAX
// bytes since the pattern began. The block takes one transaction per cycle;
// each passes an input register, a combinational parallel window compare
// against the stored pattern, and a result register. A stalled result holds
// the input register, and with it the input side, until the result is taken.
// The pattern is kept across texts.
module substring_first_match
    import ssm_pkg::*;
#(
    parameter int TEXT_MAX    = 127,
    parameter int PATTERN_MAX = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int PLEN_W = $clog2(PATTERN_MAX + 1);

    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    res_valid_reg, res_valid_next;
    result_t res_reg;
    logic    accept;
    logic    go;
    logic    produce;

    logic [BYTE_W-1:0] pat_bytes [PATTERN_MAX];
    logic [PLEN_W-1:0] pat_len;
    logic              pat_done;
    logic              pat_ovf;
    logic              ovf_set;
    logic              found;
    logic [POS_W-1:0]  position;

    // Advance the held transaction when the result register is free or draining.
    assign go         = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !go;
    assign accept     = item_valid && !item_stall;
    assign produce    = go && (s1_item_reg.kind == KIND_TEXT) && s1_item_reg.last;

    ssm_pattern #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_pattern (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (go && (s1_item_reg.kind == KIND_PATTERN)),
        .byte_value (s1_item_reg.byte_value),
        .last       (s1_item_reg.last),
        .ovf_set    (ovf_set),
        .pat_bytes  (pat_bytes),
        .pat_len    (pat_len),
        .pat_done   (pat_done),
        .ovf        (pat_ovf)
    );

    ssm_text #(
        .TEXT_MAX    (TEXT_MAX),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_text (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (go && (s1_item_reg.kind == KIND_TEXT)),
        .byte_value (s1_item_reg.byte_value),
        .last       (s1_item_reg.last),
        .pat_bytes  (pat_bytes),
        .pat_len    (pat_len),
        .pat_done   (pat_done),
        .found      (found),
        .position   (position),
        .ovf_set    (ovf_set)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (produce)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (produce)
        begin
            res_reg.found    <= found;
            res_reg.position <= position;
            res_reg.overflow <= pat_ovf || ovf_set;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> rtl/core/ssm_pattern.sv
// ----------------------------------------------------------------------------
// ssm_pattern
// Pattern store, pattern length, completion flag and sticky overflow flag.
// The store is a shift line: the newest pattern byte sits at index 0, so the
// pattern lines up with the text window index for index.
// ----------------------------------------------------------------------------
module ssm_pattern
    import ssm_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    localparam int PLEN_W = $clog2(PATTERN_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              last,
    input  logic              ovf_set,
    output logic [BYTE_W-1:0] pat_bytes [PATTERN_MAX],
    output logic [PLEN_W-1:0] pat_len,
    output logic              pat_done,
    output logic              ovf
);

    logic [BYTE_W-1:0] pat_reg [PATTERN_MAX];
    logic [PLEN_W-1:0] len_reg, len_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [PLEN_W-1:0] eff_len;
    logic              full;

    // A pattern byte after a finished pattern starts a new one.
    assign eff_len = done_reg ? '0 : len_reg;
    assign full    = (eff_len == PLEN_W'(PATTERN_MAX));

    always_comb
    begin
        len_next  = len_reg;
        done_next = done_reg;
        ovf_next  = ovf_reg | ovf_set;
        if (load)
        begin
            len_next  = full ? eff_len : eff_len + 1'b1;
            done_next = last;
            ovf_next  = (done_reg ? 1'b0 : ovf_reg) | full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Drop bytes once the store is full.
    always_ff @(posedge clk)
    begin
        if (load && !full)
        begin
            pat_reg[0] <= byte_value;
            for (int i = 1; i < PATTERN_MAX; i++)
            begin
                pat_reg[i] <= pat_reg[i-1];
            end
        end
    end

    assign pat_bytes = pat_reg;
    assign pat_len   = len_reg;
    assign pat_done  = done_reg;
    assign ovf       = ovf_reg;

endmodule

>>> rtl/core/ssm_text.sv
// ----------------------------------------------------------------------------
// ssm_text
// Text window, text count and first-match record. Compares the shifted window
// against the pattern in parallel for every text byte.
// ----------------------------------------------------------------------------
module ssm_text
    import ssm_pkg::*;
#(
    parameter int TEXT_MAX    = 127,
    parameter int PATTERN_MAX = 16,
    localparam int PLEN_W = $clog2(PATTERN_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              last,
    input  logic [BYTE_W-1:0] pat_bytes [PATTERN_MAX],
    input  logic [PLEN_W-1:0] pat_len,
    input  logic              pat_done,
    output logic              found,
    output logic [POS_W-1:0]  position,
    output logic              ovf_set
);

    localparam int CNT_W = $clog2(TEXT_MAX + 1);
    localparam int SUM_W = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;

    logic [BYTE_W-1:0] win_reg [PATTERN_MAX];
    logic [BYTE_W-1:0] win_new [PATTERN_MAX];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              seen_reg, seen_next;
    logic [CNT_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  start_now;
    logic [PATTERN_MAX-1:0] hit;
    logic              room;
    logic              match_now;

    assign room    = (cnt_reg < CNT_W'(TEXT_MAX));
    assign cnt_inc = cnt_reg + 1'b1;
    assign ovf_set = step && !room;

    always_comb
    begin
        win_new[0] = byte_value;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            win_new[i] = win_reg[i-1];
        end
    end

    // Positions beyond the pattern length always agree.
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            hit[j] = (PLEN_W'(j) >= pat_len) || (pat_bytes[j] == win_new[j]);
        end
    end

    assign match_now = room && !seen_reg && pat_done && (pat_len != '0)
                       && (SUM_W'(cnt_inc) >= SUM_W'(pat_len)) && (&hit);
    assign start_now = CNT_W'(SUM_W'(cnt_inc) - SUM_W'(pat_len));

    assign found    = seen_reg || match_now;
    assign position = seen_reg  ? POS_W'(start_reg) :
                      match_now ? POS_W'(start_now) : '0;

    always_comb
    begin
        cnt_next   = cnt_reg;
        seen_next  = seen_reg;
        start_next = start_reg;
        if (step)
        begin
            if (last)
            begin
                cnt_next   = '0;
                seen_next  = 1'b0;
                start_next = '0;
            end
            else if (room)
            begin
                cnt_next = cnt_inc;
                if (match_now)
                begin
                    seen_next  = 1'b1;
                    start_next = start_now;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            start_reg <= start_next;
        end
    end

    // Window entries past the text count are never compared.
    always_ff @(posedge clk)
    begin
        if (step && room)
        begin
            win_reg <= win_new;
        end
    end

endmodule

>>> rtl/core/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks for the substring search block, bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker
    import ssm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // A miss reports position zero.
    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.position == '0)
        else $error("result position nonzero without a match");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A new result follows an accepted last text byte through the input and result registers.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |->
            $past(item_valid && !item_stall && item.kind == KIND_TEXT && item.last, 2))
        else $error("result without a last text transaction");

    // An idle input side never stalls.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid && !item_stall |=> !item_stall)
        else $error("input stalled with nothing pending");

endmodule

bind substring_first_match ssm_checker u_ssm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
